[src/priority_round_robin_task_scheduler_macros.svh]
// Assertion macros for the task scheduler checkers
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRRTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRRTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/prrts_pkg.sv]
// Shared types and constants for the task scheduler
`timescale 1ns / 1ps
package prrts_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_SCHED = 2'd1,
		OP_SLEEP = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic       CFG_ACTIVE   = 1'b0;
	localparam logic       CFG_PRIO     = 1'b1;
	localparam logic [1:0] IDLE_LEVEL   = 2'd3;
	localparam int         LEVELS       = 4;
	localparam int         PRIO_TASKS   = 8;
	localparam logic [3:0] ACTIVE_RESET = 4'd1;

	typedef struct packed {
		logic tick;
		logic sleep;
		logic scan_init;
		logic wake_step;
		logic load_ptr;
		logic reduce_step;
		logic pick_step;
		logic force_idle;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic any_ready;
		logic ptr_big;
		logic pick_hit;
	} sts_t;

endpackage

[src/prrts_ctrl.sv]
// Scheduler controller: accepts commands and sequences the table scans
`timescale 1ns / 1ps
module prrts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  prrts_pkg::sts_t   sts,
	output prrts_pkg::cmd_t   cmd,
	output logic              busy
);
	import prrts_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WAKE   = 5'b00010,
		ST_LOAD   = 5'b00100,
		ST_REDUCE = 5'b01000,
		ST_PICK   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_TICK:  cmd.tick = 1'b1;
						OP_SLEEP: cmd.sleep = 1'b1;
						OP_SCHED: begin
							cmd.scan_init = 1'b1;
							state_d       = ST_WAKE;
						end
						default: ;
					endcase
				end
			end
			ST_WAKE: begin
				cmd.wake_step = 1'b1;
				if (sts.scan_last) begin
					if (sts.any_ready) begin
						state_d = ST_LOAD;
					end else begin
						cmd.force_idle = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_ptr = 1'b1;
				state_d      = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.reduce_step = 1'b1;
				if (!sts.ptr_big) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				cmd.pick_step = 1'b1;
				if (sts.pick_hit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/prrts_dp.sv]
// Scheduler datapath: tick counter, task table, level pointers, result registers
`timescale 1ns / 1ps
module prrts_dp #(
	parameter int NUM_TASKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prrts_pkg::cmd_t   cmd,
	output prrts_pkg::sts_t   sts,
	input  logic [31:0]       sleep_ticks,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              done,
	output logic [2:0]        selected_task,
	output logic [1:0]        selected_level,
	output logic              idle_forced
);
	import prrts_pkg::*;

	localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = $clog2(NUM_TASKS + 1);

	logic [3:0]    active_q;
	logic [15:0]   prio_q;
	logic [31:0]   tick_q;
	logic [NUM_TASKS-1:0] sleep_q;
	logic [31:0]   wake_q [NUM_TASKS];
	logic [TW-1:0] ptr_q [LEVELS];
	logic [TW-1:0] running_q;
	logic [TW-1:0] pos_q;
	logic          best_vld_q;
	logic [1:0]    best_lvl_q;
	logic          done_q;
	logic [2:0]    res_task_q;
	logic [1:0]    res_lvl_q;
	logic          res_idle_q;

	logic [1:0]    prio_v [NUM_TASKS];
	logic [CW-1:0] n_c;
	logic [CW-1:0] pos_ext;
	logic          wrap;
	logic [TW-1:0] pos_next;
	logic          due;
	logic          ready;
	logic          better;

	for (genvar t = 0; t < NUM_TASKS; t++) begin : g_prio
		if (t == 0 || t >= PRIO_TASKS) begin : g_idle
			assign prio_v[t] = IDLE_LEVEL;
		end else begin : g_cfg
			assign prio_v[t] = prio_q[2*t+1 -: 2];
		end
	end

	always_comb begin
		if (active_q == '0) begin
			n_c = CW'(1);
		end else if (32'(active_q) > NUM_TASKS) begin
			n_c = CW'(NUM_TASKS);
		end else begin
			n_c = CW'(active_q);
		end
	end

	assign pos_ext  = CW'(pos_q);
	assign wrap     = (pos_ext + CW'(1)) == n_c;
	assign pos_next = wrap ? '0 : pos_q + TW'(1);
	assign due      = sleep_q[pos_q] && (tick_q >= wake_q[pos_q]);
	assign ready    = !sleep_q[pos_q] || due;
	assign better   = ready && (!best_vld_q || (prio_v[pos_q] < best_lvl_q));

	assign sts.scan_last = wrap;
	assign sts.any_ready = best_vld_q || ready;
	assign sts.ptr_big   = pos_ext >= n_c;
	assign sts.pick_hit  = (prio_v[pos_q] == best_lvl_q) && !sleep_q[pos_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= ACTIVE_RESET;
			prio_q     <= '1;
			tick_q     <= '0;
			sleep_q    <= '0;
			running_q  <= '0;
			pos_q      <= '0;
			best_vld_q <= 1'b0;
			best_lvl_q <= IDLE_LEVEL;
			done_q     <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				ptr_q[l] <= '0;
			end
		end else begin
			done_q <= (cmd.pick_step && sts.pick_hit) || cmd.force_idle;
			if (cfg_we) begin
				if (cfg_index == CFG_ACTIVE) begin
					active_q <= cfg_data[3:0];
				end else begin
					prio_q <= cfg_data;
				end
			end
			if (cmd.tick) begin
				tick_q <= tick_q + 32'd1;
			end
			if (cmd.sleep) begin
				sleep_q[running_q] <= 1'b1;
			end
			if (cmd.scan_init) begin
				pos_q      <= '0;
				best_vld_q <= 1'b0;
			end
			if (cmd.wake_step) begin
				if (due) begin
					sleep_q[pos_q] <= 1'b0;
				end
				if (better) begin
					best_vld_q <= 1'b1;
					best_lvl_q <= prio_v[pos_q];
				end
				pos_q <= pos_next;
			end
			if (cmd.force_idle) begin
				sleep_q[0] <= 1'b0;
				running_q  <= '0;
			end
			if (cmd.load_ptr) begin
				pos_q <= ptr_q[best_lvl_q];
			end
			if (cmd.reduce_step && sts.ptr_big) begin
				pos_q <= TW'(pos_ext - n_c);
			end
			if (cmd.pick_step) begin
				if (sts.pick_hit) begin
					ptr_q[best_lvl_q] <= pos_next;
					running_q         <= pos_q;
				end else begin
					pos_q <= pos_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sleep) begin
			wake_q[running_q] <= tick_q + sleep_ticks;
		end
		if (cmd.force_idle) begin
			res_task_q <= '0;
			res_lvl_q  <= IDLE_LEVEL;
			res_idle_q <= 1'b1;
		end else if (cmd.pick_step && sts.pick_hit) begin
			res_task_q <= 3'(pos_q);
			res_lvl_q  <= best_lvl_q;
			res_idle_q <= 1'b0;
		end
	end

	assign done           = done_q;
	assign selected_task  = res_task_q;
	assign selected_level = res_lvl_q;
	assign idle_forced    = res_idle_q;

endmodule

[src/priority_round_robin_task_scheduler.sv]
// Top level of the fixed-priority round-robin task scheduler
//
//  channel   handshake        payload
//  command   start / busy     opcode, sleep_ticks
//  result    done (strobe)    selected_task, selected_level, idle_forced
//  config    cfg_we           cfg_index, cfg_data
//
// Tick, sleep and unused opcodes complete in the accepting cycle; busy stays low.
// Schedule: a wake scan over the n active tasks, a pointer load, pointer reduce
// steps and a pick scan (n = active task count), run on the single shared scan
// index over the task table; done pulses the cycle after the pick.
// A new command may be accepted in the cycle done is high.
// arst_n clears the counter, flags, pointers and config to their reset values.
`timescale 1ns / 1ps
module priority_round_robin_task_scheduler #(
	parameter int NUM_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] sleep_ticks,
	output logic        done,
	output logic [2:0]  selected_task,
	output logic [1:0]  selected_level,
	output logic        idle_forced,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import prrts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	prrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	prrts_dp #(
		.NUM_TASKS (NUM_TASKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sleep_ticks    (sleep_ticks),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.selected_task  (selected_task),
		.selected_level (selected_level),
		.idle_forced    (idle_forced)
	);

endmodule

[src/prrts_chk.sv]
// Port-level checker for the task scheduler, bound to the top level
`timescale 1ns / 1ps
`include "priority_round_robin_task_scheduler_macros.svh"
module prrts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  opcode,
	input logic [31:0] sleep_ticks,
	input logic        done,
	input logic [2:0]  selected_task,
	input logic [1:0]  selected_level,
	input logic        idle_forced,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [15:0] cfg_data
);
	import prrts_pkg::*;

	`PRRTS_ASSERT_NEXT(a_done_single, done, !done, "done strobe lasted two cycles")
	`PRRTS_ASSERT_IMPL(a_done_idle, done, !busy, "result shown while still busy")
	`PRRTS_ASSERT_NEXT(a_sched_busy, start && !busy && opcode == OP_SCHED, busy && !done, "schedule transaction did not start a scan")
	`PRRTS_ASSERT_NEXT(a_other_quiet, start && !busy && opcode != OP_SCHED, !busy && !done, "non-schedule transaction caused a result")
	`PRRTS_ASSERT_IMPL(a_forced_idle, done && idle_forced, selected_task == 3'd0 && selected_level == IDLE_LEVEL, "forced idle result is not task 0 at idle level")

endmodule

bind priority_round_robin_task_scheduler prrts_chk u_prrts_chk (.*);
